// ===== hw/rtl/compressed_bitmap_run_decoder_top_assert.svh =====
// assertion macros shared by the decoder top level
`ifndef COMPRESSED_BITMAP_RUN_DECODER_TOP_ASSERT_SVH
`define COMPRESSED_BITMAP_RUN_DECODER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CBRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CBRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cbrd_pkg.sv =====
`timescale 1ns / 1ps

package cbrd_pkg;

  localparam int RECORD_DEPTH_DEF  = 64;
  localparam int HISTORY_DEPTH_DEF = 4096;

  localparam int COORD_W = 16;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 6;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [COUNT_W-1:0] count_t;

  // run types in the top two bits of a header
  localparam logic [1:0] HDR_ZERO   = 2'b00;
  localparam logic [1:0] HDR_ONES   = 2'b01;
  localparam logic [1:0] HDR_LIT    = 2'b10;
  localparam logic [1:0] HDR_REPLAY = 2'b11;

  localparam byte_t FILL_ZERO = 8'h00;
  localparam byte_t FILL_ONES = 8'hFF;
  localparam byte_t END_MARK  = 8'h00;

  // configuration register indexes
  localparam logic [1:0] REG_ORIGIN_X     = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y     = 2'd1;
  localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd2;
  localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd3;

  localparam coord_t GLYPH_WIDTH_RST  = 16'd8;
  localparam coord_t GLYPH_HEIGHT_RST = 16'd8;
  localparam coord_t COLUMN_STEP      = 16'd8;

endpackage

// ===== hw/rtl/cbrd_ifs.sv =====
`timescale 1ns / 1ps

interface cbrd_in_if;
  logic                valid;
  logic                ready;
  cbrd_pkg::byte_t     stream_byte;
  logic                glyph_start;

  modport source (output valid, output stream_byte, output glyph_start, input ready);
  modport sink   (input valid, input stream_byte, input glyph_start, output ready);
endinterface

interface cbrd_out_if;
  logic                valid;
  logic                ready;
  cbrd_pkg::coord_t    pixel_x;
  cbrd_pkg::coord_t    pixel_y;
  cbrd_pkg::byte_t     pixel_bits;
  logic                last_of_run;

  modport source (output valid, output pixel_x, output pixel_y, output pixel_bits,
                  output last_of_run, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input pixel_bits,
                  input last_of_run, output ready);
endinterface

// ===== hw/rtl/compressed_bitmap_run_decoder_top.sv =====
// flow: an accepted byte is decoded in DECODE; a literal data byte is emitted from there, a fill
//   run from FILL, and a replay reads its record (RREAD, RUSE), then history (HRD) before each result (HEMIT)
// a new input byte is taken only once the sequencer is back in IDLE, so each byte, fill run or replay
//   finishes first (one history memory read port, read then emit per byte)
// reset: synchronous active low; config returns to defaults, memories are not cleared
`timescale 1ns / 1ps

`include "compressed_bitmap_run_decoder_top_assert.svh"

module compressed_bitmap_run_decoder_top #(
  parameter int RECORD_DEPTH  = cbrd_pkg::RECORD_DEPTH_DEF,
  parameter int HISTORY_DEPTH = cbrd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  cbrd_in_if.sink             in_ch,
  cbrd_out_if.source          out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int RW = (RECORD_DEPTH > 1) ? $clog2(RECORD_DEPTH) : 1;
  localparam int CW = $clog2(RECORD_DEPTH + 1);
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int EW = HW + cbrd_pkg::COUNT_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DECODE = 3'd1;
  localparam logic [2:0] ST_FILL   = 3'd2;
  localparam logic [2:0] ST_RREAD  = 3'd3;
  localparam logic [2:0] ST_RUSE   = 3'd4;
  localparam logic [2:0] ST_HRD    = 3'd5;
  localparam logic [2:0] ST_HEMIT  = 3'd6;

  // configuration
  cbrd_pkg::coord_t origin_x_r, origin_y_r, width_r, height_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= cbrd_pkg::GLYPH_WIDTH_RST;
      height_r   <= cbrd_pkg::GLYPH_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        cbrd_pkg::REG_ORIGIN_X:     origin_x_r <= cfg_pwdata[15:0];
        cbrd_pkg::REG_ORIGIN_Y:     origin_y_r <= cfg_pwdata[15:0];
        cbrd_pkg::REG_GLYPH_WIDTH:  width_r    <= cfg_pwdata[15:0];
        cbrd_pkg::REG_GLYPH_HEIGHT: height_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      cbrd_pkg::REG_ORIGIN_X:     cfg_prdata = {16'd0, origin_x_r};
      cbrd_pkg::REG_ORIGIN_Y:     cfg_prdata = {16'd0, origin_y_r};
      cbrd_pkg::REG_GLYPH_WIDTH:  cfg_prdata = {16'd0, width_r};
      cbrd_pkg::REG_GLYPH_HEIGHT: cfg_prdata = {16'd0, height_r};
      default:                    cfg_prdata = '0;
    endcase
  end

  // sequencer state
  logic [2:0]         state_r, state_nxt;
  cbrd_pkg::byte_t    byte_r, byte_nxt;
  cbrd_pkg::coord_t   column_r, column_nxt, row_r, row_nxt;
  cbrd_pkg::count_t   lit_left_r, lit_left_nxt;
  logic               finished_r, finished_nxt;
  logic [CW-1:0]      rec_count_r, rec_count_nxt;
  logic [RW-1:0]      rec_head_r, rec_head_nxt;
  logic [HW-1:0]      hptr_r, hptr_nxt;
  logic [HW-1:0]      hrd_addr_r, hrd_addr_nxt;
  logic [RW-1:0]      rec_rd_addr_r, rec_rd_addr_nxt;
  cbrd_pkg::count_t   cnt_r, cnt_nxt;

  // memories
  cbrd_pkg::byte_t    hist_mem [HISTORY_DEPTH];
  cbrd_pkg::byte_t    hist_q_r;
  logic [EW-1:0]      rec_mem [RECORD_DEPTH];
  logic [EW-1:0]      rec_q_r;
  logic               hist_we, rec_we;
  logic [RW-1:0]      rec_wr_slot;

  // output register
  logic               out_valid_r;
  cbrd_pkg::coord_t   out_x_r, out_y_r;
  cbrd_pkg::byte_t    out_bits_r;
  logic               out_last_r;

  logic               emit_ok, emit_en, emit_last;
  cbrd_pkg::byte_t    emit_bits;
  cbrd_pkg::count_t   n;
  logic [1:0]         hdr_type;
  logic [7:0]         rep_sum, wr_sum;
  logic [RW-1:0]      rep_slot, wr_slot, head_inc;
  logic [HW-1:0]      hptr_inc, hrd_inc;
  cbrd_pkg::coord_t   col_adv;
  logic               in_take;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign emit_ok     = !out_valid_r || out_ch.ready;

  assign n        = byte_r[5:0];
  assign hdr_type = byte_r[7:6];

  // record slots stay below twice the depth, so one compare and subtract wraps them
  assign rep_sum  = 8'(rec_head_r) + 8'(n);
  assign wr_sum   = 8'(rec_head_r) + 8'(rec_count_r);
  assign rep_slot = (rep_sum >= 8'(RECORD_DEPTH)) ? RW'(rep_sum - 8'(RECORD_DEPTH))
                                                  : RW'(rep_sum);
  assign wr_slot  = (wr_sum >= 8'(RECORD_DEPTH)) ? RW'(wr_sum - 8'(RECORD_DEPTH))
                                                 : RW'(wr_sum);
  assign head_inc = (rec_head_r == RW'(RECORD_DEPTH - 1)) ? '0 : RW'(rec_head_r + 1'b1);
  assign hptr_inc = (hptr_r == HW'(HISTORY_DEPTH - 1)) ? '0 : HW'(hptr_r + 1'b1);
  assign hrd_inc  = (hrd_addr_r == HW'(HISTORY_DEPTH - 1)) ? '0 : HW'(hrd_addr_r + 1'b1);
  assign col_adv  = column_r + cbrd_pkg::COLUMN_STEP;

  always_comb begin
    state_nxt       = state_r;
    byte_nxt        = byte_r;
    column_nxt      = column_r;
    row_nxt         = row_r;
    lit_left_nxt    = lit_left_r;
    finished_nxt    = finished_r;
    rec_count_nxt   = rec_count_r;
    rec_head_nxt    = rec_head_r;
    hptr_nxt        = hptr_r;
    hrd_addr_nxt    = hrd_addr_r;
    rec_rd_addr_nxt = rec_rd_addr_r;
    cnt_nxt         = cnt_r;
    hist_we         = 1'b0;
    rec_we          = 1'b0;
    rec_wr_slot     = wr_slot;
    emit_en         = 1'b0;
    emit_last       = 1'b0;
    emit_bits       = byte_r;

    case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          byte_nxt  = in_ch.stream_byte;
          state_nxt = ST_DECODE;
          if (in_ch.glyph_start) begin
            column_nxt    = '0;
            row_nxt       = '0;
            lit_left_nxt  = '0;
            finished_nxt  = 1'b0;
            rec_count_nxt = '0;
            rec_head_nxt  = '0;
            hptr_nxt      = '0;
          end
        end
      end
      ST_DECODE: begin
        if (finished_r) begin
          state_nxt = ST_IDLE;
        end else if (lit_left_r != '0) begin
          if (emit_ok) begin
            emit_en      = 1'b1;
            emit_last    = 1'b1;
            hist_we      = 1'b1;
            hptr_nxt     = hptr_inc;
            lit_left_nxt = lit_left_r - 1'b1;
            state_nxt    = ST_IDLE;
          end
        end else if (byte_r == cbrd_pkg::END_MARK || row_r >= height_r) begin
          finished_nxt = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          state_nxt = ST_IDLE;
          case (hdr_type)
            cbrd_pkg::HDR_ZERO, cbrd_pkg::HDR_ONES: begin
              if (n != '0) begin
                cnt_nxt   = n;
                state_nxt = ST_FILL;
              end
            end
            cbrd_pkg::HDR_LIT: begin
              rec_we = 1'b1;
              if (rec_count_r == CW'(RECORD_DEPTH)) begin
                rec_wr_slot  = rec_head_r;
                rec_head_nxt = head_inc;
              end else begin
                rec_count_nxt = rec_count_r + 1'b1;
              end
              lit_left_nxt = n;
            end
            cbrd_pkg::HDR_REPLAY: begin
              if (8'(n) < 8'(rec_count_r)) begin
                rec_rd_addr_nxt = rep_slot;
                state_nxt       = ST_RREAD;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        emit_bits = (hdr_type == cbrd_pkg::HDR_ONES) ? cbrd_pkg::FILL_ONES
                                                     : cbrd_pkg::FILL_ZERO;
        if (emit_ok) begin
          emit_en   = 1'b1;
          emit_last = (cnt_r == 6'd1);
          cnt_nxt   = cnt_r - 1'b1;
          if (cnt_r == 6'd1) state_nxt = ST_IDLE;
        end
      end
      ST_RREAD: begin
        state_nxt = ST_RUSE;
      end
      ST_RUSE: begin
        if (rec_q_r[cbrd_pkg::COUNT_W-1:0] == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          hrd_addr_nxt = rec_q_r[EW-1:cbrd_pkg::COUNT_W];
          cnt_nxt      = rec_q_r[cbrd_pkg::COUNT_W-1:0];
          state_nxt    = ST_HRD;
        end
      end
      ST_HRD: begin
        state_nxt = ST_HEMIT;
      end
      ST_HEMIT: begin
        emit_bits = hist_q_r;
        if (emit_ok) begin
          emit_en      = 1'b1;
          emit_last    = (cnt_r == 6'd1);
          cnt_nxt      = cnt_r - 1'b1;
          hrd_addr_nxt = hrd_inc;
          state_nxt    = (cnt_r == 6'd1) ? ST_IDLE : ST_HRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // column steps by 8 and wraps to the next row at the width
    if (emit_en) begin
      if (col_adv >= width_r) begin
        column_nxt = '0;
        row_nxt    = row_r + 1'b1;
      end else begin
        column_nxt = col_adv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      column_r      <= '0;
      row_r         <= '0;
      lit_left_r    <= '0;
      finished_r    <= 1'b0;
      rec_count_r   <= '0;
      rec_head_r    <= '0;
      hptr_r        <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      column_r      <= column_nxt;
      row_r         <= row_nxt;
      lit_left_r    <= lit_left_nxt;
      finished_r    <= finished_nxt;
      rec_count_r   <= rec_count_nxt;
      rec_head_r    <= rec_head_nxt;
      hptr_r        <= hptr_nxt;
      cnt_r         <= cnt_nxt;
      if (emit_en) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r        <= byte_nxt;
    hrd_addr_r    <= hrd_addr_nxt;
    rec_rd_addr_r <= rec_rd_addr_nxt;
    if (emit_en) begin
      out_x_r    <= origin_x_r + column_r;
      out_y_r    <= origin_y_r + row_r;
      out_bits_r <= emit_bits;
      out_last_r <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hptr_r] <= byte_r;
    hist_q_r <= hist_mem[hrd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wr_slot] <= {hptr_r, n};
    rec_q_r <= rec_mem[rec_rd_addr_r];
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_x     = out_x_r;
  assign out_ch.pixel_y     = out_y_r;
  assign out_ch.pixel_bits  = out_bits_r;
  assign out_ch.last_of_run = out_last_r;

  `CBRD_ASSERT_NEXT(a_take_decodes, in_take, state_r == ST_DECODE, "request not decoded")
  `CBRD_ASSERT_NOW(a_no_emit_finished, emit_en, !finished_r, "result while finished")
  `CBRD_ASSERT_NOW(a_count_bound, 1'b1, rec_count_r <= CW'(RECORD_DEPTH), "record count overrun")
  `CBRD_ASSERT_NOW(a_emit_slot_free, emit_en, emit_ok, "result overwrote pending output")

endmodule
